@@ src/encoder_position_stepper_control_macros.svh @@
// assertion helpers shared by the top module and the divider
`ifndef ENCODER_POSITION_STEPPER_CONTROL_MACROS_SVH
`define ENCODER_POSITION_STEPPER_CONTROL_MACROS_SVH

`ifndef SYNTHESIS
`define EPSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define EPSC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define EPSC_ASSERT(lbl, prop, msg)
`define EPSC_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

@@ src/epsc_pkg.sv @@
package epsc_pkg;

  localparam int unsigned POS_W      = 31;
  localparam int unsigned ERR_W      = 32;
  localparam int unsigned WORD_W     = 16;
  localparam int unsigned ANGLE_W    = 14;
  localparam int unsigned FORCE_W    = 16;
  localparam int unsigned SPEED_W    = 10;
  localparam int unsigned SPM_W      = 9;
  localparam int unsigned DIVISOR_W  = SPEED_W + SPM_W;
  localparam int unsigned INTERVAL_W = 32;
  localparam int unsigned DELTA_W    = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 31;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_POS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_FORCE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS_SPEED  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT       = 3'd4;

  // 500 mm at 16383 counts per 8 mm
  localparam logic signed [POS_W-1:0]   HOME_COUNTS = 31'sd1023938;
  localparam logic signed [POS_W-1:0]   POS_MAX     = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0]   POS_MIN     = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic [ANGLE_W-1:0]        LOW_WRAP    = 14'd2048;
  localparam logic [ANGLE_W-1:0]        HIGH_WRAP   = 14'd14335;
  localparam logic signed [DELTA_W-1:0] TURN_COUNTS = 16'sd16383;
  localparam logic signed [ERR_W-1:0]   POS_TOL     = 32'sd512;
  localparam logic signed [FORCE_W:0]   FORCE_TOL   = 17'sd128;
  localparam logic [SPM_W-1:0]          SPM_MICRO   = 9'd400;
  localparam logic [SPM_W-1:0]          SPM_FULL    = 9'd25;
  localparam logic [SPEED_W-1:0]        SPEED_RESET = 10'd10;
  localparam logic [SPEED_W-1:0]        TRANS_RESET = 10'd17;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DELTA,
    S_POS,
    S_ERR,
    S_DIV,
    S_DONE
  } epsc_state_e;

  typedef struct packed {
    logic load;
    logic delta;
    logic apply;
    logic err;
  } epsc_trk_ctl_t;

endpackage

@@ src/epsc_intf.sv @@
interface epsc_in_if;
  import epsc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [WORD_W-1:0]         encoder_word;
  logic                      home_switch;
  logic                      start_homing;
  logic signed [FORCE_W-1:0] force_sample;

  modport source (
    output valid, encoder_word, home_switch, start_homing, force_sample,
    input  ready
  );
  modport sink (
    input  valid, encoder_word, home_switch, start_homing, force_sample,
    output ready
  );
endinterface

interface epsc_out_if;
  import epsc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] position_counts;
  logic signed [ERR_W-1:0] position_error;
  logic                    reading_valid;
  logic                    position_fault;
  logic                    force_fault;
  logic                    direction;
  logic                    position_mode;
  logic                    in_position;
  logic                    microstep_on;
  logic [INTERVAL_W-1:0]   step_interval;

  modport source (
    output valid, position_counts, position_error, reading_valid, position_fault,
           force_fault, direction, position_mode, in_position, microstep_on,
           step_interval,
    input  ready
  );
  modport sink (
    input  valid, position_counts, position_error, reading_valid, position_fault,
           force_fault, direction, position_mode, in_position, microstep_on,
           step_interval,
    output ready
  );
endinterface

@@ src/encoder_position_stepper_control.sv @@
// Absolute encoder position tracker with stepper control outputs. One beat on in_i
// (encoder reply, home switch, homing request, force sample) gives exactly one beat
// on out_o. The step timer interval is formed by a bit-serial divider, one quotient
// bit per cycle, which is skipped when speed_mm_s is zero. in_i is ready whenever no
// item is being worked on, even while the previous result waits on out_o. A homing
// request also resets target_position to 0 and speed_mm_s to 10 mm/s. Configuration
// registers are written through cfg_we_i/cfg_idx_i/cfg_wdata_i; the user must do so
// only while no item is in flight, as the block itself does not enforce this.
`include "encoder_position_stepper_control_macros.svh"

module encoder_position_stepper_control #(
  parameter int unsigned TICK_RATE_HZ = 1000000
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  epsc_in_if.sink                            in_i,
  epsc_out_if.source                         out_o,
  input  logic                               cfg_we_i,
  input  logic [epsc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [epsc_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);
  import epsc_pkg::*;

  epsc_state_e state_q, state_d;
  epsc_trk_ctl_t trk_ctl;

  logic signed [POS_W-1:0]   tpos_q;
  logic signed [FORCE_W-1:0] tforce_q;
  logic [SPEED_W-1:0]        speed_q, trans_q;
  logic                      invert_q;

  logic signed [FORCE_W-1:0] force_q;
  logic [DIVISOR_W-1:0]      divisor_q;
  logic                      micro_q;

  logic                      in_fire, div_start, div_busy, div_done, out_load;
  logic [INTERVAL_W-1:0]     div_quot;
  logic signed [POS_W-1:0]   trk_pos;
  logic signed [ERR_W-1:0]   trk_err;
  logic                      trk_valid;

  logic signed [FORCE_W:0]   ferr;
  logic                      pmode, pfault, ffault, dir;

  logic                      out_valid_q;

  assign in_fire  = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);

  // configuration registers, homing overrides target and speed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpos_q   <= '0;
      tforce_q <= '0;
      speed_q  <= SPEED_RESET;
      trans_q  <= TRANS_RESET;
      invert_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_TARGET_POS:   tpos_q   <= cfg_wdata_i[POS_W-1:0];
          REG_TARGET_FORCE: tforce_q <= cfg_wdata_i[FORCE_W-1:0];
          REG_SPEED:        speed_q  <= cfg_wdata_i[SPEED_W-1:0];
          REG_TRANS_SPEED:  trans_q  <= cfg_wdata_i[SPEED_W-1:0];
          REG_INVERT:       invert_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (in_fire && in_i.start_homing) begin
        tpos_q  <= '0;
        speed_q <= SPEED_RESET;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    trk_ctl   = '0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          trk_ctl.load = 1'b1;
          state_d      = S_DELTA;
        end
      end
      S_DELTA: begin
        trk_ctl.delta = 1'b1;
        state_d       = S_POS;
      end
      S_POS: begin
        trk_ctl.apply = 1'b1;
        state_d       = S_ERR;
      end
      S_ERR: begin
        trk_ctl.err = 1'b1;
        if (speed_q != '0) begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      force_q <= in_i.force_sample;
    end
    if (state_q == S_DELTA) begin
      micro_q   <= (speed_q <= trans_q);
      divisor_q <= DIVISOR_W'(speed_q) *
                   DIVISOR_W'((speed_q <= trans_q) ? SPM_MICRO : SPM_FULL);
    end
  end

  epsc_track u_track (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (trk_ctl),
    .word_i         (in_i.encoder_word),
    .home_switch_i  (in_i.home_switch),
    .start_homing_i (in_i.start_homing),
    .invert_i       (invert_q),
    .target_i       (tpos_q),
    .pos_o          (trk_pos),
    .err_o          (trk_err),
    .valid_o        (trk_valid)
  );

  epsc_div #(
    .TICK_RATE_HZ (TICK_RATE_HZ)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (divisor_q),
    .busy_o    (div_busy),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  always_comb begin
    ferr   = $signed({tforce_q[FORCE_W-1], tforce_q}) - $signed({force_q[FORCE_W-1], force_q});
    pmode  = (tforce_q == '0);
    pfault = (trk_err >= POS_TOL) || (trk_err <= -POS_TOL);
    ffault = (ferr > FORCE_TOL) || (ferr < -FORCE_TOL);
    // drive toward the selected error, zero counts as negative
    if (pmode) begin
      dir = trk_err[ERR_W-1] || (trk_err == '0);
    end else begin
      dir = ferr[FORCE_W] || (ferr == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_o.position_counts <= trk_pos;
      out_o.position_error  <= trk_err;
      out_o.reading_valid   <= trk_valid;
      out_o.position_fault  <= pfault;
      out_o.force_fault     <= ffault;
      out_o.direction       <= dir;
      out_o.position_mode   <= pmode;
      out_o.in_position     <= pmode && !pfault;
      out_o.microstep_on    <= micro_q;
      out_o.step_interval   <= (speed_q == '0) ? '1 : div_quot;
    end
  end

  assign out_o.valid = out_valid_q;

  `EPSC_ASSERT(a_out_from_done, $rose(out_valid_q) |-> $past(state_q == S_DONE), "result not from done")
  `EPSC_ASSERT(a_div_running, (state_q == S_DIV) |-> (div_busy || div_done), "waiting on idle divider")
  `EPSC_ASSERT_NEVER(a_no_zero_div, (state_q == S_DIV) && (speed_q == '0), "divide by zero speed")

endmodule

@@ src/epsc_track.sv @@
module epsc_track (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  epsc_pkg::epsc_trk_ctl_t          ctl_i,
  input  logic [epsc_pkg::WORD_W-1:0]      word_i,
  input  logic                             home_switch_i,
  input  logic                             start_homing_i,
  input  logic                             invert_i,
  input  logic signed [epsc_pkg::POS_W-1:0] target_i,
  output logic signed [epsc_pkg::POS_W-1:0] pos_o,
  output logic signed [epsc_pkg::ERR_W-1:0] err_o,
  output logic                             valid_o
);
  import epsc_pkg::*;

  logic signed [POS_W-1:0]   pos_q, pos_d, pos_sat;
  logic [ANGLE_W-1:0]        prev_q, prev_d, angle;
  logic                      homed_q, homed_d;
  logic [WORD_W-1:0]         word_q;
  logic signed [DELTA_W-1:0] delta_q, raw, wrapped;
  logic                      valid_q;
  logic signed [ERR_W-1:0]   err_q, sum;

  assign angle = word_q[ANGLE_W-1:0];

  always_comb begin
    raw = $signed({2'b00, angle}) - $signed({2'b00, prev_q});
    // crossing the zero point in either direction
    if (angle < LOW_WRAP && prev_q > HIGH_WRAP) begin
      wrapped = raw + TURN_COUNTS;
    end else if (angle > HIGH_WRAP && prev_q < LOW_WRAP) begin
      wrapped = raw - TURN_COUNTS;
    end else begin
      wrapped = raw;
    end
  end

  always_comb begin
    sum = {pos_q[POS_W-1], pos_q} + {{(ERR_W-DELTA_W){delta_q[DELTA_W-1]}}, delta_q};
    if (sum[ERR_W-1] != sum[ERR_W-2]) begin
      pos_sat = sum[ERR_W-1] ? POS_MIN : POS_MAX;
    end else begin
      pos_sat = sum[POS_W-1:0];
    end
  end

  always_comb begin
    pos_d   = pos_q;
    homed_d = homed_q;
    prev_d  = prev_q;
    if (ctl_i.load) begin
      if (start_homing_i) begin
        homed_d = 1'b0;
        pos_d   = HOME_COUNTS;
      end
      if (!home_switch_i && !homed_d) begin
        homed_d = 1'b1;
        pos_d   = '0;
      end
    end
    if (ctl_i.apply && valid_q) begin
      pos_d  = pos_sat;
      prev_d = angle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= HOME_COUNTS;
      prev_q  <= '0;
      homed_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      prev_q  <= prev_d;
      homed_q <= homed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      word_q <= word_i;
    end
    if (ctl_i.delta) begin
      valid_q <= ~^word_q;
      delta_q <= invert_i ? -wrapped : wrapped;
    end
    if (ctl_i.err) begin
      err_q <= {target_i[POS_W-1], target_i} - {pos_q[POS_W-1], pos_q};
    end
  end

  assign pos_o   = pos_q;
  assign err_o   = err_q;
  assign valid_o = valid_q;

endmodule

@@ src/epsc_div.sv @@
`include "encoder_position_stepper_control_macros.svh"

module epsc_div #(
  parameter int unsigned TICK_RATE_HZ = 1000000
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [epsc_pkg::DIVISOR_W-1:0]    divisor_i,
  output logic                              busy_o,
  output logic                              done_o,
  output logic [epsc_pkg::INTERVAL_W-1:0]   quot_o
);
  import epsc_pkg::*;

  localparam int unsigned QW = $clog2(TICK_RATE_HZ + 1);
  localparam int unsigned CW = $clog2(QW + 1);
  localparam logic [QW-1:0] DIVIDEND = QW'(TICK_RATE_HZ);
  localparam logic [CW-1:0] STEPS    = CW'(QW);
  localparam logic [CW-1:0] LAST     = CW'(1);

  logic                 busy_q, done_q;
  logic [CW-1:0]        cnt_q;
  logic [QW-1:0]        quo_q;
  logic [DIVISOR_W-1:0] rem_q, den_q;
  logic [DIVISOR_W:0]   trial, diff;
  logic                 fits;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial = {rem_q, quo_q[QW-1]};
    diff  = trial - {1'b0, den_q};
    fits  = trial >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= STEPS;
      end else if (busy_q) begin
        cnt_q <= cnt_q - LAST;
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= divisor_i;
      rem_q <= '0;
      quo_q <= DIVIDEND;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_q <= {quo_q[QW-2:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = INTERVAL_W'(quo_q);

  `EPSC_ASSERT(a_no_restart, start_i |-> !busy_q, "divider restarted while busy")
  `EPSC_ASSERT(a_done_ends_run, done_q |-> ($past(busy_q) && !busy_q), "done without a run")

endmodule
